### hdl/gdc_pkg.sv
package gdc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_ZERO_POINT = 2'd1;
  localparam logic [1:0] CFG_SCALE = 2'd2;
  localparam logic [1:0] CFG_STRIDE = 2'd3;

  // fixed-point constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [19:0] SIZE_MAX_Q8 = 20'hFFFFF;
  localparam int unsigned TAYLOR_TERMS = 6;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_DEQ   = 4'd1,
    OP_EXPT  = 4'd2,
    OP_EXPY  = 4'd3,
    OP_TAYA  = 4'd4,
    OP_TAYB  = 4'd5,
    OP_POW   = 4'd6,
    OP_SHIFT = 4'd7,
    OP_CEN   = 4'd8,
    OP_EDGE  = 4'd9,
    OP_SCA   = 4'd10,
    OP_SCS   = 4'd11,
    OP_SCH   = 4'd12,
    OP_SCL   = 4'd13
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;   // box index or Taylor term number
    logic       axis;  // 0: x / width, 1: y / height
    logic       acc;   // input request taken this cycle
    logic       load;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic hit;  // request on the input closes a cell in the grid that passes the threshold
  } sts_t;

  // ceil(2^24 / k): exact quotient for 17-bit dividends
  function automatic logic [24:0] recip(input logic [2:0] k);
    logic [24:0] r;
    case (k)
      3'd1:    r = 25'd16777216;
      3'd2:    r = 25'd8388608;
      3'd3:    r = 25'd5592406;
      3'd4:    r = 25'd4194304;
      3'd5:    r = 25'd3355444;
      3'd6:    r = 25'd2796203;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/gdc_ctrl.sv
module gdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  gdc_pkg::sts_t sts,
  output gdc_pkg::cmd_t cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DEQ   = 15'b000000000000010,
    S_EXPT  = 15'b000000000000100,
    S_EXPY  = 15'b000000000001000,
    S_TAYA  = 15'b000000000010000,
    S_TAYB  = 15'b000000000100000,
    S_POW   = 15'b000000001000000,
    S_SHIFT = 15'b000000010000000,
    S_CEN   = 15'b000000100000000,
    S_EDGE  = 15'b000001000000000,
    S_SCA   = 15'b000010000000000,
    S_SCS   = 15'b000100000000000,
    S_SCH   = 15'b001000000000000,
    S_SCL   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       axis_r, axis_nxt;
  logic       oval_r, oval_nxt;
  logic       acc;
  logic       load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign acc        = in_tvalid && in_tready;
  assign load       = (state_r == S_DONE) && (!oval_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (acc && sts.hit) begin
          state_nxt = S_DEQ;
          cnt_nxt   = 3'd0;
          axis_nxt  = 1'b0;
        end
      end
      S_DEQ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          state_nxt = S_EXPT;
        end
      end
      S_EXPT: state_nxt = S_EXPY;
      S_EXPY: begin
        state_nxt = S_TAYA;
        cnt_nxt   = 3'd1;
      end
      S_TAYA: state_nxt = S_TAYB;
      S_TAYB: begin
        if (cnt_r == 3'(gdc_pkg::TAYLOR_TERMS)) begin
          state_nxt = S_POW;
        end else begin
          state_nxt = S_TAYA;
          cnt_nxt   = cnt_r + 3'd1;
        end
      end
      S_POW: state_nxt = S_SHIFT;
      S_SHIFT: begin
        axis_nxt  = !axis_r;
        state_nxt = axis_r ? S_CEN : S_EXPT;
      end
      S_CEN: state_nxt = S_EDGE;
      S_EDGE: begin
        axis_nxt  = !axis_r;
        state_nxt = axis_r ? S_SCA : S_CEN;
      end
      S_SCA: state_nxt = S_SCS;
      S_SCS: state_nxt = S_SCH;
      S_SCH: state_nxt = S_SCL;
      S_SCL: state_nxt = S_DONE;
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    oval_nxt = oval_r;
    if (load) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  // command decode
  always_comb begin
    cmd.idx  = cnt_r;
    cmd.axis = axis_r;
    cmd.acc  = acc;
    cmd.load = load;
    case (state_r)
      S_DEQ:   cmd.op = gdc_pkg::OP_DEQ;
      S_EXPT:  cmd.op = gdc_pkg::OP_EXPT;
      S_EXPY:  cmd.op = gdc_pkg::OP_EXPY;
      S_TAYA:  cmd.op = gdc_pkg::OP_TAYA;
      S_TAYB:  cmd.op = gdc_pkg::OP_TAYB;
      S_POW:   cmd.op = gdc_pkg::OP_POW;
      S_SHIFT: cmd.op = gdc_pkg::OP_SHIFT;
      S_CEN:   cmd.op = gdc_pkg::OP_CEN;
      S_EDGE:  cmd.op = gdc_pkg::OP_EDGE;
      S_SCA:   cmd.op = gdc_pkg::OP_SCA;
      S_SCS:   cmd.op = gdc_pkg::OP_SCS;
      S_SCH:   cmd.op = gdc_pkg::OP_SCH;
      S_SCL:   cmd.op = gdc_pkg::OP_SCL;
      default: cmd.op = gdc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      axis_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!oval_r || out_tready)) else $error("result overwritten");

  // a loaded result is presented next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid) else $error("loaded result not presented");

  // Taylor term number stays in range
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAYB) |-> (cnt_r >= 3'd1 && cnt_r <= 3'd6))
    else $error("Taylor term out of range");

  // no request taken while a cell is being decoded
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !acc) else $error("request taken while busy");

endmodule

### hdl/gdc_dp.sv
module gdc_dp #(
  parameter int NUM_CLASSES = 80,
  parameter int GRID_MAX    = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata,
  input  logic [31:0]   in_tdata,
  input  logic          in_tlast,
  input  gdc_pkg::cmd_t cmd,
  output gdc_pkg::sts_t sts,
  output logic [111:0]  out_tdata
);

  // configuration
  logic signed [7:0] thr_r, zp_r;
  logic [15:0]       scale_r;
  logic [6:0]        stride_r;

  // cell state
  logic signed [7:0] box_r [4];
  logic signed [7:0] obj_r, best_r;
  logic [6:0]        cls_r;
  logic signed [7:0] obj_nxt, best_nxt;
  logic [6:0]        cls_nxt;
  logic [6:0]        row_r, col_r;

  // input fields
  logic [6:0]        in_row, in_col, in_ch;
  logic signed [7:0] in_val;
  logic [8:0]        kcls;

  // working registers
  logic signed [25:0] dx_r, dy_r, dw_r, dh_r;
  logic signed [25:0] t_r;
  logic signed [9:0]  n_r;
  logic [15:0]        y_r;
  logic [16:0]        term_r, tmp_r;
  logic [17:0]        sum_r;
  logic [24:0]        p_r;
  logic [19:0]        w_r, h_r;
  logic signed [25:0] c8_r;
  logic signed [20:0] left_r, top_r;
  logic signed [17:0] a_r;
  logic [31:0]        s2_r;
  logic [32:0]        ph_r;
  logic [15:0]        score_r;

  // shared multiplier
  logic signed [27:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [53:0] mul_p;

  // combinational helpers
  logic signed [25:0] d_sel;
  logic [16:0]        a_pos;
  logic [16:0]        term_new;
  logic signed [10:0] e_s;
  logic [10:0]        ne;
  logic [44:0]        shl_v;
  logic [24:0]        shr_v;
  logic [19:0]        size_v;
  logic [19:0]        size_sel;
  logic signed [26:0] edge_v;
  logic signed [20:0] edge_sat;
  logic [33:0]        sc_sum;

  assign in_row = in_tdata[6:0];
  assign in_col = in_tdata[13:7];
  assign in_ch  = in_tdata[20:14];
  assign in_val = signed'(in_tdata[28:21]);
  assign kcls   = {2'b0, in_ch} - 9'd5;

  // next objectness / class maximum, used for the threshold decision
  always_comb begin
    obj_nxt  = obj_r;
    best_nxt = best_r;
    cls_nxt  = cls_r;
    if (in_ch == 7'd4) begin
      obj_nxt = in_val;
    end else if (in_ch > 7'd4 && kcls < 9'(NUM_CLASSES)) begin
      if (kcls == 9'd0 || in_val > best_r) begin
        best_nxt = in_val;
        cls_nxt  = kcls[6:0];
      end
    end
  end

  assign sts.hit = in_tlast
                 && ({2'b0, in_row} < 9'(GRID_MAX))
                 && ({2'b0, in_col} < 9'(GRID_MAX))
                 && (obj_nxt >= thr_r) && (best_nxt >= thr_r);

  assign a_pos    = (a_r > 18'sd0) ? a_r[16:0] : 17'd0;
  assign d_sel    = cmd.axis ? (cmd.op == gdc_pkg::OP_CEN ? dy_r : dh_r)
                             : (cmd.op == gdc_pkg::OP_CEN ? dx_r : dw_r);
  assign size_sel = cmd.axis ? h_r : w_r;

  // operand selection
  always_comb begin
    mul_a = 28'sd0;
    mul_b = 26'sd0;
    case (cmd.op)
      gdc_pkg::OP_DEQ: begin
        mul_a = 28'(signed'({box_r[cmd.idx[1:0]][7], box_r[cmd.idx[1:0]]})
                    - signed'({zp_r[7], zp_r}));
        mul_b = signed'({10'b0, scale_r});
      end
      gdc_pkg::OP_EXPT: begin
        mul_a = 28'(d_sel);
        mul_b = signed'({9'b0, gdc_pkg::LOG2E_Q16});
      end
      gdc_pkg::OP_EXPY: begin
        mul_a = signed'({12'b0, t_r[15:0]});
        mul_b = signed'({10'b0, gdc_pkg::LN2_Q16});
      end
      gdc_pkg::OP_TAYA: begin
        mul_a = signed'({11'b0, term_r});
        mul_b = signed'({10'b0, y_r});
      end
      gdc_pkg::OP_TAYB: begin
        mul_a = signed'({11'b0, tmp_r});
        mul_b = signed'({1'b0, gdc_pkg::recip(cmd.idx)});
      end
      gdc_pkg::OP_POW: begin
        mul_a = signed'({10'b0, sum_r});
        mul_b = signed'({19'b0, stride_r});
      end
      gdc_pkg::OP_CEN: begin
        mul_a = 28'(d_sel) + signed'({5'b0, (cmd.axis ? row_r : col_r), 16'b0});
        mul_b = signed'({19'b0, stride_r});
      end
      gdc_pkg::OP_SCA: begin
        mul_a = 28'(signed'({obj_r[7], obj_r}) - signed'({zp_r[7], zp_r}));
        mul_b = 26'(signed'({best_r[7], best_r}) - signed'({zp_r[7], zp_r}));
      end
      gdc_pkg::OP_SCS: begin
        mul_a = signed'({12'b0, scale_r});
        mul_b = signed'({10'b0, scale_r});
      end
      gdc_pkg::OP_SCH: begin
        mul_a = signed'({11'b0, a_pos});
        mul_b = signed'({10'b0, s2_r[31:16]});
      end
      gdc_pkg::OP_SCL: begin
        mul_a = signed'({11'b0, a_pos});
        mul_b = signed'({10'b0, s2_r[15:0]});
      end
      default: begin
        mul_a = 28'sd0;
        mul_b = 26'sd0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign term_new = mul_p[40:24];

  // size = p * 2^(n-8), saturated
  assign e_s   = signed'({n_r[9], n_r}) - 11'sd8;
  assign ne    = 11'(-e_s);
  assign shl_v = {20'b0, p_r} << e_s[4:0];
  assign shr_v = p_r >> ne[4:0];
  always_comb begin
    if (p_r == 25'd0) begin
      size_v = 20'd0;
    end else if (!e_s[10]) begin
      if (e_s >= 11'sd20 || shl_v > 45'(gdc_pkg::SIZE_MAX_Q8)) begin
        size_v = gdc_pkg::SIZE_MAX_Q8;
      end else begin
        size_v = shl_v[19:0];
      end
    end else if (ne >= 11'd25) begin
      size_v = 20'd0;
    end else if (shr_v > 25'(gdc_pkg::SIZE_MAX_Q8)) begin
      size_v = gdc_pkg::SIZE_MAX_Q8;
    end else begin
      size_v = shr_v[19:0];
    end
  end

  // edge = centre - size/2, saturated to 21 bits
  assign edge_v = signed'({c8_r[25], c8_r}) - signed'({8'b0, size_sel[19:1]});
  always_comb begin
    if (edge_v > 27'sd1048575) begin
      edge_sat = 21'sd1048575;
    end else if (edge_v < -27'sd1048576) begin
      edge_sat = -21'sd1048576;
    end else begin
      edge_sat = edge_v[20:0];
    end
  end

  assign sc_sum = {1'b0, ph_r} + {17'b0, mul_p[32:16]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= 8'sd0;
      zp_r     <= 8'sd0;
      scale_r  <= 16'd256;
      stride_r <= 7'd8;
    end else if (cfg_we) begin
      case (cfg_addr)
        gdc_pkg::CFG_THRESHOLD:  thr_r    <= signed'(cfg_wdata[7:0]);
        gdc_pkg::CFG_ZERO_POINT: zp_r     <= signed'(cfg_wdata[7:0]);
        gdc_pkg::CFG_SCALE:      scale_r  <= cfg_wdata;
        gdc_pkg::CFG_STRIDE:     stride_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // cell state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= 8'sd0;
      box_r[1] <= 8'sd0;
      box_r[2] <= 8'sd0;
      box_r[3] <= 8'sd0;
      obj_r    <= 8'sd0;
      best_r   <= 8'sd0;
      cls_r    <= 7'd0;
    end else if (cmd.acc) begin
      if (in_ch < 7'd4) begin
        box_r[in_ch[1:0]] <= in_val;
      end
      obj_r  <= obj_nxt;
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    case (cmd.op)
      gdc_pkg::OP_DEQ: begin
        case (cmd.idx[1:0])
          2'd0:    dx_r <= mul_p[25:0];
          2'd1:    dy_r <= mul_p[25:0];
          2'd2:    dw_r <= mul_p[25:0];
          default: dh_r <= mul_p[25:0];
        endcase
      end
      gdc_pkg::OP_EXPT: t_r <= mul_p[41:16];
      gdc_pkg::OP_EXPY: begin
        y_r    <= mul_p[31:16];
        n_r    <= t_r[25:16];
        term_r <= gdc_pkg::ONE_Q16;
        sum_r  <= {1'b0, gdc_pkg::ONE_Q16};
      end
      gdc_pkg::OP_TAYA: tmp_r <= mul_p[32:16];
      gdc_pkg::OP_TAYB: begin
        term_r <= term_new;
        sum_r  <= sum_r + {1'b0, term_new};
      end
      gdc_pkg::OP_POW: p_r <= mul_p[24:0];
      gdc_pkg::OP_SHIFT: begin
        if (cmd.axis) begin
          h_r <= size_v;
        end else begin
          w_r <= size_v;
        end
      end
      gdc_pkg::OP_CEN: c8_r <= mul_p[33:8];
      gdc_pkg::OP_EDGE: begin
        if (cmd.axis) begin
          top_r <= edge_sat;
        end else begin
          left_r <= edge_sat;
        end
      end
      gdc_pkg::OP_SCA: a_r  <= mul_p[17:0];
      gdc_pkg::OP_SCS: s2_r <= mul_p[31:0];
      gdc_pkg::OP_SCH: ph_r <= mul_p[32:0];
      gdc_pkg::OP_SCL: score_r <= (sc_sum > 34'd65535) ? 16'hFFFF : sc_sum[15:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tdata <= {7'b0, score_r, cls_r, h_r, w_r, top_r, left_r};
    end
  end

endmodule

### hdl/grid_detection_cell_decoder.sv
// Grid detection cell decoder.
// Input stream: one int8 channel value per request, cells sent channel by
// channel (box x, y, w, h, objectness, then class scores); tlast marks the
// last channel of a cell. Config is written through cfg_we/cfg_addr/cfg_wdata;
// the user must do so only while the block is idle; the block does not enforce it.
// Requests that do not close a passing cell stream at one per clock while the
// block is idle. A request closing a cell whose objectness and best class
// both reach the threshold starts a decode run on the single shared 28x26
// multiplier: dequantise the box values, compute the two exp sizes
// (six-term Taylor series, term n being a multiply by y and one by 1/n),
// the two centres and edges, the score and a load step, during which tready
// is low; out_tvalid goes high in the cycle after the load step.
// The detection then sits in the output register; the input side is free again
// while it waits. A second passing cell finishes its decode and then holds
// until the receiver takes the first detection.
// Reset (synchronous, active low) restores the default config, clears the
// cell state and drops out_tvalid. A stalled receiver holds tdata unchanged.
module grid_detection_cell_decoder #(
  parameter int NUM_CLASSES = 80,
  parameter int GRID_MAX    = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [6:0] cell_row, [13:7] cell_col, [20:14] channel, [28:21] value
  input  logic [31:0]  in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [20:0] box_left, [41:21] box_top, [61:42] box_width, [81:62] box_height,
  // [88:82] class_id, [104:89] score
  output logic [111:0] out_tdata
);

  gdc_pkg::cmd_t cmd;
  gdc_pkg::sts_t sts;

  gdc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gdc_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .GRID_MAX    (GRID_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
